// ===== src/tfn_pkg.sv =====
package tfn_pkg;

  localparam int unsigned OUT_W = 16;

  typedef struct packed {
    logic signed [OUT_W-1:0] norm_x;
    logic signed [OUT_W-1:0] norm_y;
    logic signed [OUT_W-1:0] norm_z;
    logic                    degenerate;
  } res_t;

endpackage

// ===== src/tfn_front.sv =====
module tfn_front #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [9*COORD_WIDTH-1:0]        coord_i,
  output logic                            valid_o,
  output logic [3*(4*COORD_WIDTH+4)-1:0]  sq_o,
  output logic [4*COORD_WIDTH+5:0]        len2_o,
  output logic [2:0]                      sgn_o
);

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned EW  = CW + 1;
  localparam int unsigned PW  = 2 * CW + 2;
  localparam int unsigned NW  = 2 * CW + 3;
  localparam int unsigned MW  = 2 * CW + 2;
  localparam int unsigned SQW = 4 * CW + 4;
  localparam int unsigned LW  = SQW + 2;

  logic [4:0] vld_q;

  logic signed [EW-1:0] u_q [3];
  logic signed [EW-1:0] v_q [3];
  logic signed [PW-1:0] prod_q [6];
  logic [MW-1:0]        mag_q [3];
  logic [2:0]           sgn3_q, sgn4_q, sgn5_q;
  logic [SQW-1:0]       sq_q [3];
  logic [SQW-1:0]       sq5_q [3];
  logic [LW-1:0]        len2_q;

  logic signed [CW-1:0] p [9];
  logic signed [NW-1:0] n [3];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      p[i] = coord_i[i*CW +: CW];
    end
    n[0] = NW'(prod_q[0]) - NW'(prod_q[1]);
    n[1] = NW'(prod_q[2]) - NW'(prod_q[3]);
    n[2] = NW'(prod_q[4]) - NW'(prod_q[5]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // edges
    for (int k = 0; k < 3; k++) begin
      u_q[k] <= EW'(p[3+k]) - EW'(p[k]);
      v_q[k] <= EW'(p[6+k]) - EW'(p[k]);
    end
    // cross product terms
    prod_q[0] <= PW'(u_q[1]) * PW'(v_q[2]);
    prod_q[1] <= PW'(u_q[2]) * PW'(v_q[1]);
    prod_q[2] <= PW'(u_q[2]) * PW'(v_q[0]);
    prod_q[3] <= PW'(u_q[0]) * PW'(v_q[2]);
    prod_q[4] <= PW'(u_q[0]) * PW'(v_q[1]);
    prod_q[5] <= PW'(u_q[1]) * PW'(v_q[0]);
    for (int k = 0; k < 3; k++) begin
      sgn3_q[k] <= n[k][NW-1];
      mag_q[k]  <= n[k][NW-1] ? MW'(-n[k]) : MW'(n[k]);
      sq_q[k]   <= SQW'(mag_q[k]) * SQW'(mag_q[k]);
      sq5_q[k]  <= sq_q[k];
    end
    sgn4_q <= sgn3_q;
    sgn5_q <= sgn4_q;
    len2_q <= LW'(sq_q[0]) + LW'(sq_q[1]) + LW'(sq_q[2]);
  end

  assign valid_o = vld_q[4];
  assign sq_o    = {sq5_q[2], sq5_q[1], sq5_q[0]};
  assign len2_o  = len2_q;
  assign sgn_o   = sgn5_q;

endmodule

// ===== src/tfn_queue.sv =====
module tfn_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [AW:0]      cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

endmodule

// ===== src/tfn_back.sv =====
module tfn_back #(
  parameter int unsigned COORD_WIDTH      = 16,
  parameter int unsigned NORMAL_FRAC_BITS = 14
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            avail_i,
  input  logic [3*(4*COORD_WIDTH+4)-1:0]  sq_i,
  input  logic [4*COORD_WIDTH+5:0]        len2_i,
  input  logic [2:0]                      sgn_i,
  output logic                            pop_o,
  output logic                            done_o,
  output tfn_pkg::res_t                   res_o
);

  localparam int unsigned F    = NORMAL_FRAC_BITS;
  localparam int unsigned SQW  = 4 * COORD_WIDTH + 4;
  localparam int unsigned W    = SQW + 2 * F + 4;
  localparam int unsigned QW   = F + 1;
  localparam int unsigned CNTW = $clog2(F + 1);
  localparam int unsigned OW   = tfn_pkg::OUT_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic             st_q, st_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic [W-1:0]     r_q [3];
  logic [W-1:0]     r_d [3];
  logic [W-1:0]     ps_q [3];
  logic [W-1:0]     ps_d [3];
  logic [W-1:0]     ls_q, ls_d;
  logic [QW-1:0]    q_q [3];
  logic [QW-1:0]    q_d [3];
  logic [2:0]       sgn_q, sgn_d;
  logic             done_q, done_d;
  tfn_pkg::res_t    res_q, res_d;

  logic [W-1:0]     delta [3];
  logic [W-1:0]     ps_n [3];
  logic [2:0]       acc;
  logic [OW-1:0]    comp [3];

  function automatic logic [OW-1:0] signed_out(input logic [QW-1:0] q, input logic neg);
    logic [QW+OW-1:0] ext;
    logic [OW-1:0]    m;
    ext = {{OW{1'b0}}, q};
    m   = ext[OW-1:0];
    return neg ? OW'(~m + 1'b1) : m;
  endfunction

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    ls_d   = ls_q >> 2;
    sgn_d  = sgn_q;
    done_d = 1'b0;
    res_d  = res_q;
    pop_o  = 1'b0;
    for (int k = 0; k < 3; k++) begin
      // try the next quotient bit on each lane
      delta[k] = ps_q[k] + ls_q;
      acc[k]   = (delta[k] <= r_q[k]);
      r_d[k]   = acc[k] ? r_q[k] - delta[k] : r_q[k];
      ps_n[k]  = acc[k] ? ps_q[k] + (ls_q << 1) : ps_q[k];
      ps_d[k]  = ps_n[k] >> 1;
      q_d[k]   = {q_q[k][QW-2:0], acc[k]};
      comp[k]  = signed_out(q_d[k], sgn_q[k]);
    end
    case (st_q)
      ST_IDLE: begin
        if (avail_i) begin
          pop_o = 1'b1;
          if (len2_i == '0) begin
            done_d = 1'b1;
            res_d  = '{norm_x: '0, norm_y: '0, norm_z: '0, degenerate: 1'b1};
          end else begin
            st_d  = ST_RUN;
            cnt_d = CNTW'(F);
            ls_d  = W'(len2_i) << (2 * F);
            sgn_d = sgn_i;
            for (int k = 0; k < 3; k++) begin
              r_d[k]  = W'(sq_i[k*SQW +: SQW]) << (2 * F);
              ps_d[k] = '0;
              q_d[k]  = '0;
            end
          end
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          st_d   = ST_IDLE;
          done_d = 1'b1;
          res_d  = '{norm_x: comp[0], norm_y: comp[1], norm_z: comp[2], degenerate: 1'b0};
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      r_q[k]  <= r_d[k];
      ps_q[k] <= ps_d[k];
      q_q[k]  <= q_d[k];
    end
    ls_q  <= ls_d;
    sgn_q <= sgn_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== src/triangle_face_normal.sv =====
// The front registers edges, cross products, magnitudes, squares and the squared length;
// the queue holds them until the shared normalizer (tfn_back) pops them. It makes one
// quotient bit per cycle on all three axes, takes a new triangle only after the last is
// done and skips the division for a degenerate one. busy goes high with 8 in flight.
// The receiver cannot stall: each result shows on done_o for one cycle.
// Reset (rst_ni low, asynchronous) empties the pipeline and queue; no clearing pass.
module triangle_face_normal #(
  parameter int unsigned COORD_WIDTH      = 16,
  parameter int unsigned NORMAL_FRAC_BITS = 14
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [COORD_WIDTH-1:0] a_x_i,
  input  logic [COORD_WIDTH-1:0] a_y_i,
  input  logic [COORD_WIDTH-1:0] a_z_i,
  input  logic [COORD_WIDTH-1:0] b_x_i,
  input  logic [COORD_WIDTH-1:0] b_y_i,
  input  logic [COORD_WIDTH-1:0] b_z_i,
  input  logic [COORD_WIDTH-1:0] c_x_i,
  input  logic [COORD_WIDTH-1:0] c_y_i,
  input  logic [COORD_WIDTH-1:0] c_z_i,
  output logic                   done_o,
  output logic signed [15:0]     norm_x_o,
  output logic signed [15:0]     norm_y_o,
  output logic signed [15:0]     norm_z_o,
  output logic                   degenerate_o
);

  localparam int unsigned SQW   = 4 * COORD_WIDTH + 4;
  localparam int unsigned LW    = SQW + 2;
  localparam int unsigned ENTW  = 3 * SQW + LW + 3;
  localparam int unsigned DEPTH = 8;
  localparam int unsigned OCCW  = $clog2(DEPTH) + 1;

  logic              accept;
  logic [OCCW-1:0]   occ_q;
  logic              f_valid;
  logic [3*SQW-1:0]  f_sq;
  logic [LW-1:0]     f_len2;
  logic [2:0]        f_sgn;
  logic              q_empty;
  logic [ENTW-1:0]   q_data;
  logic              pop;
  tfn_pkg::res_t     res;

  assign accept = start && !busy;
  assign busy   = (occ_q == OCCW'(DEPTH));

  // count triangles accepted and not yet taken by the normalizer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_q + OCCW'(accept) - OCCW'(pop);
    end
  end

  tfn_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .coord_i ({c_z_i, c_y_i, c_x_i, b_z_i, b_y_i, b_x_i, a_z_i, a_y_i, a_x_i}),
    .valid_o (f_valid),
    .sq_o    (f_sq),
    .len2_o  (f_len2),
    .sgn_o   (f_sgn)
  );

  tfn_queue #(.WIDTH(ENTW), .DEPTH(DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  ({f_sgn, f_len2, f_sq}),
    .pop_i   (pop),
    .empty_o (q_empty),
    .data_o  (q_data)
  );

  tfn_back #(
    .COORD_WIDTH      (COORD_WIDTH),
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (!q_empty),
    .sq_i    (q_data[3*SQW-1:0]),
    .len2_i  (q_data[3*SQW +: LW]),
    .sgn_i   (q_data[ENTW-1 -: 3]),
    .pop_o   (pop),
    .done_o  (done_o),
    .res_o   (res)
  );

  assign norm_x_o     = res.norm_x;
  assign norm_y_o     = res.norm_y;
  assign norm_z_o     = res.norm_z;
  assign degenerate_o = res.degenerate;

endmodule

// ===== src/tfn_checker.sv =====
module tfn_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input logic signed [15:0] norm_x_o,
  input logic signed [15:0] norm_y_o,
  input logic signed [15:0] norm_z_o,
  input logic               degenerate_o
);

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && degenerate_o |-> norm_x_o == 0 && norm_y_o == 0 && norm_z_o == 0)
    else $error("degenerate result with nonzero normal");

  a_unit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !degenerate_o |-> norm_x_o != 0 || norm_y_o != 0 || norm_z_o != 0)
    else $error("nondegenerate result with zero normal");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !done_o)
    else $error("result strobe right after reset");

  a_busy_after_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !busy)
    else $error("busy right after reset");

  // busy rises only on the word that fills the last slot
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> $past(start) || $past(busy))
    else $error("busy rose without an accepted word");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (.*);
